// ----- rtl/psre_pkg.sv -----
// shared types, constants and limits of the png stored-deflate encoder
`default_nettype none

package psre_pkg;

    localparam int unsigned MAX_WIDTH   = 8192;
    localparam int unsigned MAX_HEIGHT  = 8192;
    localparam int unsigned SIZE_W      = 14;
    localparam int unsigned POS_W       = 13;
    localparam int unsigned ROWLEN_W    = 15;
    localparam int unsigned RAW_W       = 28;
    localparam int unsigned BLOCKS_W    = 13;
    localparam int unsigned CFG_DATA_W  = 14;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [31:0] CRC_POLY   = 32'hedb88320;
    localparam logic [31:0] CRC_INIT   = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [16:0] BLOCK_MAX  = 17'd65535;
    localparam logic [7:0]  ZLIB_CMF   = 8'h78;
    localparam logic [7:0]  ZLIB_FLG   = 8'h01;
    localparam logic [7:0]  BIT_DEPTH  = 8'd8;
    localparam logic [7:0]  COLOUR_RGB = 8'd2;
    localparam logic [31:0] IHDR_LEN   = 32'd13;
    localparam logic [31:0] IDAT_FIXED = 32'd6;

    localparam logic [63:0] PNG_SIG    = 64'h89504e470d0a1a0a;
    localparam logic [31:0] CHUNK_IHDR = 32'h49484452;
    localparam logic [31:0] CHUNK_IDAT = 32'h49444154;
    localparam logic [31:0] CHUNK_IEND = 32'h49454e44;

    // byte positions inside the header and trailer sequences
    localparam logic [5:0] HDR_IHDR_TYPE = 6'd12;
    localparam logic [5:0] HDR_IHDR_END  = 6'd28;
    localparam logic [5:0] HDR_IDAT_TYPE = 6'd37;
    localparam logic [5:0] HDR_LAST      = 6'd42;
    localparam logic [5:0] TRL_ADLER_END = 6'd3;
    localparam logic [5:0] TRL_IEND_TYPE = 6'd12;
    localparam logic [5:0] TRL_IEND_END  = 6'd15;
    localparam logic [5:0] TRL_LAST      = 6'd19;
    localparam logic [5:0] BLK_LAST      = 6'd4;

    typedef struct packed {
        logic       hdr;
        logic       filt;
        logic       trl;
        logic       pix;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } op_t;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [RAW_W-1:0]  raw;
        logic [31:0]       idat_len;
    } size_t;

endpackage

`default_nettype wire

// ----- rtl/psre_pix_if.sv -----
// pixel request channel
`default_nettype none

interface psre_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/psre_byte_if.sv -----
// output byte request channel
`default_nettype none

interface psre_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/psre_front.sv -----
// front end: size registers, image position tracking and per-pixel op classification
`default_nettype none

module psre_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    psre_pix_if.sink                           pixel,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [psre_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          q_full,
    output logic                               push,
    output psre_pkg::op_t                      push_op,
    output psre_pkg::size_t                    size
);

    logic [psre_pkg::SIZE_W-1:0]   cfg_w_reg, cfg_h_reg;
    logic [psre_pkg::SIZE_W-1:0]   w_now, h_now;
    logic                          hdr_sent_reg, hdr_sent_next;
    logic                          pend_reg, pend_next;
    logic [psre_pkg::POS_W-1:0]    col_reg, col_next, col_cur;
    logic [psre_pkg::POS_W-1:0]    row_reg, row_next, row_cur;
    logic [psre_pkg::SIZE_W-1:0]   col_inc, row_inc;
    logic                          wrap, last, hdr;

    logic [psre_pkg::SIZE_W-1:0]   w_reg, h_reg;
    logic [psre_pkg::ROWLEN_W-1:0] rowlen_reg;
    logic [psre_pkg::RAW_W-1:0]    raw_reg;
    logic [psre_pkg::BLOCKS_W-1:0] blocks_reg, blocks_next;
    logic [31:0]                   len_reg;
    logic [11:0]                   q0;
    logic [16:0]                   rem0, rem1;
    logic                          rem_ge;

    assign w_now = (cfg_w_reg == '0) ? psre_pkg::SIZE_W'(1) :
                   (cfg_w_reg > psre_pkg::SIZE_W'(psre_pkg::MAX_WIDTH)) ?
                   psre_pkg::SIZE_W'(psre_pkg::MAX_WIDTH) : cfg_w_reg;
    assign h_now = (cfg_h_reg == '0) ? psre_pkg::SIZE_W'(1) :
                   (cfg_h_reg > psre_pkg::SIZE_W'(psre_pkg::MAX_HEIGHT)) ?
                   psre_pkg::SIZE_W'(psre_pkg::MAX_HEIGHT) : cfg_h_reg;

    assign pixel.ready = !q_full;
    assign push        = pixel.valid && !q_full;

    always_comb
    begin
        hdr     = !pend_reg && !hdr_sent_reg;
        col_cur = hdr ? '0 : col_reg;
        row_cur = hdr ? '0 : row_reg;
        col_inc = {1'b0, col_cur} + psre_pkg::SIZE_W'(1);
        row_inc = {1'b0, row_cur} + psre_pkg::SIZE_W'(1);
        wrap    = col_inc >= w_now;
        last    = wrap && (row_inc >= h_now);

        push_op.hdr   = hdr;
        push_op.filt  = !pend_reg && (col_cur == '0);
        push_op.trl   = pend_reg || (last && !hdr);
        push_op.pix   = !pend_reg;
        push_op.red   = pixel.pixel_red;
        push_op.green = pixel.pixel_green;
        push_op.blue  = pixel.pixel_blue;

        if (pend_reg)
        begin
            pend_next     = 1'b0;
            hdr_sent_next = 1'b0;
            col_next      = col_reg;
            row_next      = row_reg;
        end
        else
        begin
            pend_next     = last && hdr;
            hdr_sent_next = !(last && !hdr);
            col_next      = wrap ? '0 : col_inc[psre_pkg::POS_W-1:0];
            row_next      = wrap ? row_inc[psre_pkg::POS_W-1:0] : row_cur;
        end
    end

    // ceil(raw / 65535) without a divider
    always_comb
    begin
        q0          = raw_reg[psre_pkg::RAW_W-1:16];
        rem0        = {1'b0, raw_reg[15:0]} + 17'(q0);
        rem_ge      = rem0 >= psre_pkg::BLOCK_MAX;
        rem1        = rem_ge ? (rem0 - psre_pkg::BLOCK_MAX) : rem0;
        blocks_next = psre_pkg::BLOCKS_W'(q0) + psre_pkg::BLOCKS_W'(rem_ge)
                    + psre_pkg::BLOCKS_W'(rem1 != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg    <= psre_pkg::SIZE_W'(1);
            cfg_h_reg    <= psre_pkg::SIZE_W'(1);
            hdr_sent_reg <= 1'b0;
            pend_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psre_pkg::CFG_WIDTH:  cfg_w_reg <= cfg_data;
                psre_pkg::CFG_HEIGHT: cfg_h_reg <= cfg_data;
                default:              cfg_w_reg <= cfg_w_reg;
            endcase
            hdr_sent_reg <= 1'b0;
            pend_reg     <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (push)
        begin
            hdr_sent_reg <= hdr_sent_next;
            pend_reg     <= pend_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    // size pipeline: row length, raw byte count, block count, idat length
    always_ff @(posedge clk)
    begin
        w_reg      <= w_now;
        h_reg      <= h_now;
        rowlen_reg <= psre_pkg::ROWLEN_W'(1) + psre_pkg::ROWLEN_W'({w_now, 1'b0})
                    + psre_pkg::ROWLEN_W'(w_now);
        raw_reg    <= psre_pkg::RAW_W'(h_reg * rowlen_reg);
        blocks_reg <= blocks_next;
        len_reg    <= psre_pkg::IDAT_FIXED + 32'(raw_reg)
                    + 32'({blocks_reg, 2'b00}) + 32'(blocks_reg);
    end

    assign size.width    = w_reg;
    assign size.height   = h_reg;
    assign size.raw      = raw_reg;
    assign size.idat_len = len_reg;

endmodule

`default_nettype wire

// ----- rtl/psre_queue.sv -----
// short op queue between front and back
`default_nettype none

module psre_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  psre_pkg::op_t       push_op,
    output logic                full,
    output logic                head_valid,
    output psre_pkg::op_t       head,
    input  wire logic           pop
);

    psre_pkg::op_t                 entry_reg [psre_pkg::QUEUE_DEPTH];
    logic [psre_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [psre_pkg::QCNT_W-1:0]   count_reg;
    logic                          do_pop;

    assign full       = count_reg == psre_pkg::QCNT_W'(psre_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + psre_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + psre_pkg::QPTR_W'(1);
            end
            case ({push && !full, do_pop})
                2'b10:   count_reg <= count_reg + psre_pkg::QCNT_W'(1);
                2'b01:   count_reg <= count_reg - psre_pkg::QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/psre_back.sv -----
// back end: byte sequencer with crc-32, adler-32 and stored block framing
`default_nettype none

module psre_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          op_valid,
    input  psre_pkg::op_t      op,
    output logic               op_pop,
    input  psre_pkg::size_t    size,
    psre_byte_if.source        stream
);

    typedef enum logic [2:0] {PH_FIRST, PH_HDR, PH_BLK, PH_RAW, PH_TRL} phase_t;

    phase_t                       phase_reg, phase_next, eff_phase;
    logic [5:0]                   cnt_reg, cnt_next, eff_cnt;
    logic [1:0]                   ridx_reg, ridx_next, eff_ridx;
    logic [31:0]                  crc_reg, crc_next, crc_base;
    logic [15:0]                  alo_reg, alo_next, ahi_reg, ahi_next;
    logic [15:0]                  blk_left_reg, blk_left_next;
    logic [psre_pkg::RAW_W-1:0]   raw_left_reg, raw_left_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;

    logic                         adv, crc_upd, crc_init, bfinal;
    logic [7:0]                   byte_val;
    logic [15:0]                  blk_n;
    logic [31:0]                  crc_fin;
    logic [16:0]                  lo_sum, hi_sum;
    logic [15:0]                  lo_new;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? (psre_pkg::CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input psre_pkg::size_t s,
                                            input logic [31:0] cf);
        logic [31:0] w32, h32;
        w32 = 32'(s.width);
        h32 = 32'(s.height);
        case (idx)
            6'd0:    return psre_pkg::PNG_SIG[63:56];
            6'd1:    return psre_pkg::PNG_SIG[55:48];
            6'd2:    return psre_pkg::PNG_SIG[47:40];
            6'd3:    return psre_pkg::PNG_SIG[39:32];
            6'd4:    return psre_pkg::PNG_SIG[31:24];
            6'd5:    return psre_pkg::PNG_SIG[23:16];
            6'd6:    return psre_pkg::PNG_SIG[15:8];
            6'd7:    return psre_pkg::PNG_SIG[7:0];
            6'd8:    return psre_pkg::IHDR_LEN[31:24];
            6'd9:    return psre_pkg::IHDR_LEN[23:16];
            6'd10:   return psre_pkg::IHDR_LEN[15:8];
            6'd11:   return psre_pkg::IHDR_LEN[7:0];
            6'd12:   return psre_pkg::CHUNK_IHDR[31:24];
            6'd13:   return psre_pkg::CHUNK_IHDR[23:16];
            6'd14:   return psre_pkg::CHUNK_IHDR[15:8];
            6'd15:   return psre_pkg::CHUNK_IHDR[7:0];
            6'd16:   return w32[31:24];
            6'd17:   return w32[23:16];
            6'd18:   return w32[15:8];
            6'd19:   return w32[7:0];
            6'd20:   return h32[31:24];
            6'd21:   return h32[23:16];
            6'd22:   return h32[15:8];
            6'd23:   return h32[7:0];
            6'd24:   return psre_pkg::BIT_DEPTH;
            6'd25:   return psre_pkg::COLOUR_RGB;
            6'd29:   return cf[31:24];
            6'd30:   return cf[23:16];
            6'd31:   return cf[15:8];
            6'd32:   return cf[7:0];
            6'd33:   return s.idat_len[31:24];
            6'd34:   return s.idat_len[23:16];
            6'd35:   return s.idat_len[15:8];
            6'd36:   return s.idat_len[7:0];
            6'd37:   return psre_pkg::CHUNK_IDAT[31:24];
            6'd38:   return psre_pkg::CHUNK_IDAT[23:16];
            6'd39:   return psre_pkg::CHUNK_IDAT[15:8];
            6'd40:   return psre_pkg::CHUNK_IDAT[7:0];
            6'd41:   return psre_pkg::ZLIB_CMF;
            6'd42:   return psre_pkg::ZLIB_FLG;
            default: return 8'd0;
        endcase
    endfunction

    assign adv     = op_valid && (!out_valid_reg || stream.ready);
    assign crc_fin = ~crc_reg;
    assign bfinal  = raw_left_reg <= psre_pkg::RAW_W'(psre_pkg::BLOCK_MAX);
    assign blk_n   = bfinal ? raw_left_reg[15:0] : psre_pkg::BLOCK_MAX[15:0];

    // where the current op stands, including its first byte
    always_comb
    begin
        eff_phase = phase_reg;
        eff_cnt   = cnt_reg;
        eff_ridx  = ridx_reg;
        if (phase_reg == PH_FIRST)
        begin
            eff_cnt  = '0;
            eff_ridx = op.filt ? 2'd0 : 2'd1;
            if (op.hdr)
            begin
                eff_phase = PH_HDR;
            end
            else if (op.pix)
            begin
                eff_phase = PH_RAW;
            end
            else
            begin
                eff_phase = PH_TRL;
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        ridx_next      = ridx_reg;
        crc_next       = crc_reg;
        alo_next       = alo_reg;
        ahi_next       = ahi_reg;
        blk_left_next  = blk_left_reg;
        raw_left_next  = raw_left_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        byte_val       = 8'd0;
        crc_upd        = 1'b0;
        crc_init       = 1'b0;
        op_pop         = 1'b0;
        lo_sum         = 17'd0;
        hi_sum         = 17'd0;
        lo_new         = 16'd0;
        crc_base       = crc_reg;

        if (adv)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            case (eff_phase)
                PH_HDR:
                begin
                    byte_val = hdr_byte(eff_cnt, size, crc_fin);
                    crc_init = (eff_cnt == psre_pkg::HDR_IHDR_TYPE)
                            || (eff_cnt == psre_pkg::HDR_IDAT_TYPE);
                    crc_upd  = (eff_cnt >= psre_pkg::HDR_IHDR_TYPE && eff_cnt <= psre_pkg::HDR_IHDR_END)
                            || (eff_cnt >= psre_pkg::HDR_IDAT_TYPE);
                    if (eff_cnt == psre_pkg::HDR_LAST)
                    begin
                        phase_next    = PH_RAW;
                        ridx_next     = op.filt ? 2'd0 : 2'd1;
                        alo_next      = 16'd1;
                        ahi_next      = 16'd0;
                        blk_left_next = 16'd0;
                        raw_left_next = size.raw;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                        cnt_next   = eff_cnt + 6'd1;
                    end
                end
                PH_RAW:
                begin
                    crc_upd = 1'b1;
                    if (blk_left_reg == '0)
                    begin
                        byte_val   = {7'd0, bfinal};
                        phase_next = PH_BLK;
                        cnt_next   = 6'd1;
                        ridx_next  = eff_ridx;
                    end
                    else
                    begin
                        case (eff_ridx)
                            2'd1:    byte_val = op.red;
                            2'd2:    byte_val = op.green;
                            2'd3:    byte_val = op.blue;
                            default: byte_val = 8'd0;
                        endcase
                        lo_sum        = {1'b0, alo_reg} + 17'(byte_val);
                        lo_new        = (lo_sum >= psre_pkg::ADLER_MOD) ?
                                        16'(lo_sum - psre_pkg::ADLER_MOD) : lo_sum[15:0];
                        hi_sum        = {1'b0, ahi_reg} + {1'b0, lo_new};
                        alo_next      = lo_new;
                        ahi_next      = (hi_sum >= psre_pkg::ADLER_MOD) ?
                                        16'(hi_sum - psre_pkg::ADLER_MOD) : hi_sum[15:0];
                        blk_left_next = blk_left_reg - 16'd1;
                        raw_left_next = raw_left_reg - psre_pkg::RAW_W'(1);
                        if (eff_ridx == 2'd3)
                        begin
                            if (op.trl)
                            begin
                                phase_next = PH_TRL;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                phase_next = PH_FIRST;
                                op_pop     = 1'b1;
                            end
                        end
                        else
                        begin
                            phase_next = PH_RAW;
                            ridx_next  = eff_ridx + 2'd1;
                        end
                    end
                end
                PH_BLK:
                begin
                    crc_upd = 1'b1;
                    case (eff_cnt[1:0])
                        2'd1:    byte_val = blk_n[7:0];
                        2'd2:    byte_val = blk_n[15:8];
                        2'd3:    byte_val = ~blk_n[7:0];
                        default: byte_val = ~blk_n[15:8];
                    endcase
                    if (eff_cnt == psre_pkg::BLK_LAST)
                    begin
                        phase_next    = PH_RAW;
                        blk_left_next = blk_n;
                    end
                    else
                    begin
                        cnt_next = eff_cnt + 6'd1;
                    end
                end
                PH_TRL:
                begin
                    case (eff_cnt)
                        6'd0:    byte_val = ahi_reg[15:8];
                        6'd1:    byte_val = ahi_reg[7:0];
                        6'd2:    byte_val = alo_reg[15:8];
                        6'd3:    byte_val = alo_reg[7:0];
                        6'd4:    byte_val = crc_fin[31:24];
                        6'd5:    byte_val = crc_fin[23:16];
                        6'd6:    byte_val = crc_fin[15:8];
                        6'd7:    byte_val = crc_fin[7:0];
                        6'd12:   byte_val = psre_pkg::CHUNK_IEND[31:24];
                        6'd13:   byte_val = psre_pkg::CHUNK_IEND[23:16];
                        6'd14:   byte_val = psre_pkg::CHUNK_IEND[15:8];
                        6'd15:   byte_val = psre_pkg::CHUNK_IEND[7:0];
                        6'd16:   byte_val = crc_fin[31:24];
                        6'd17:   byte_val = crc_fin[23:16];
                        6'd18:   byte_val = crc_fin[15:8];
                        6'd19:   byte_val = crc_fin[7:0];
                        default: byte_val = 8'd0;
                    endcase
                    crc_init = eff_cnt == psre_pkg::TRL_IEND_TYPE;
                    crc_upd  = (eff_cnt <= psre_pkg::TRL_ADLER_END)
                            || (eff_cnt >= psre_pkg::TRL_IEND_TYPE && eff_cnt <= psre_pkg::TRL_IEND_END);
                    if (eff_cnt == psre_pkg::TRL_LAST)
                    begin
                        out_last_next = 1'b1;
                        phase_next    = PH_FIRST;
                        op_pop        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TRL;
                        cnt_next   = eff_cnt + 6'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
            out_byte_next = byte_val;
            if (crc_upd)
            begin
                crc_base = crc_init ? psre_pkg::CRC_INIT : crc_reg;
                crc_next = crc_byte(crc_base, byte_val);
            end
        end
        else if (stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            cnt_reg       <= '0;
            ridx_reg      <= '0;
            crc_reg       <= psre_pkg::CRC_INIT;
            alo_reg       <= 16'd1;
            ahi_reg       <= 16'd0;
            blk_left_reg  <= '0;
            raw_left_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            ridx_reg      <= ridx_next;
            crc_reg       <= crc_next;
            alo_reg       <= alo_next;
            ahi_reg       <= ahi_next;
            blk_left_reg  <= blk_left_next;
            raw_left_reg  <= raw_left_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign stream.valid     = out_valid_reg;
    assign stream.out_byte  = out_byte_reg;
    assign stream.last_byte = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/png_stored_rgb_encoder.sv -----
// top level of the png encoder with stored (uncompressed) deflate for 8-bit rgb images
//
// pixels arrive on the pixel channel in raster order, one request per pixel; the file
// stream leaves on the stream channel one byte per request, last_byte marking the final
// byte of the iend chunk. image_width and image_height are set through the write port
// (cfg_index 0 and 1); the user must write them only while the block is idle, which the
// block itself does not enforce; a write abandons any image in progress. the first pixel
// of an image brings out the signature, ihdr and the idat/zlib headers (43 bytes), every
// pixel brings its three colour bytes, plus a filter byte at the start of a row and a
// five byte block header every 65535 raw bytes; the last pixel adds the 20 byte trailer
// (a one pixel image sends its trailer on the following pixel, whose colour is dropped).
// the back sequencer writes one byte per cycle into the output register while the
// receiver is ready; a pixel's bytes pass the op queue and then the output register.
// a four-entry op queue lets the pixel side run ahead while the receiver stalls;
// pixel.ready drops when it is full. the ihdr sizes follow a write through the size
// pipeline. reset sets both sizes to one and empties the queue and the output register.
`default_nettype none

module png_stored_rgb_encoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    psre_pix_if.sink                             pixel,
    psre_byte_if.source                          stream,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [psre_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic            push, q_full, head_valid, pop;
    psre_pkg::op_t   push_op, head;
    psre_pkg::size_t size;

    psre_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_op   (push_op),
        .size      (size)
    );

    psre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    psre_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (head_valid),
        .op       (head),
        .op_pop   (pop),
        .size     (size),
        .stream   (stream)
    );

endmodule

`default_nettype wire

// ----- bench/png_stored_rgb_encoder_tb.sv -----
// self-checking testbench for the png stored-deflate rgb encoder with its own byte predictor
module png_stored_rgb_encoder_tb;
    import psre_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 1_500_000;
    localparam int unsigned STEP_BYTES_MAX = 52;
    localparam int unsigned TRAILER_LEN    = 20;
    localparam int unsigned RANDOM_PIXELS  = 86;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         hold;
    } pixel_req_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } file_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    psre_pix_if  pix_ch();
    psre_byte_if byte_ch();

    png_stored_rgb_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_ch),
        .stream    (byte_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [SIZE_W-1:0] reg_width;
    logic [SIZE_W-1:0] reg_height;
    logic [31:0]       crc_q;
    logic [15:0]       adler_a;
    logic [15:0]       adler_b;
    logic [SIZE_W-1:0] col_pos;
    logic [SIZE_W-1:0] row_pos;
    logic [15:0]       block_left;
    logic [RAW_W-1:0]  raw_left;
    bit                header_done;
    bit                trailer_owed;
    int unsigned       step_bytes;

    file_byte_t  bytes_due[$];
    pixel_req_t  pixels_pending[$];
    pixel_req_t  pix_cur;

    int unsigned pixels_outstanding;
    int unsigned pixels_sent;
    int unsigned bytes_seen;
    int unsigned files_closed;
    int unsigned reg_writes;
    int unsigned failures;
    int unsigned gap_max;
    int unsigned stall_max;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned cycle_count;

    function automatic void flag_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    function automatic void push_byte(logic [7:0] value, logic last);
        file_byte_t fb;
        if (step_bytes < STEP_BYTES_MAX)
        begin
            fb.value = value;
            fb.last  = last;
            bytes_due.push_back(fb);
            step_bytes++;
        end
    endfunction

    function automatic void push_crc_byte(logic [7:0] value);
        crc_q = crc_q ^ {24'd0, value};
        for (int k = 0; k < 8; k++)
            crc_q = crc_q[0] ? (CRC_POLY ^ (crc_q >> 1)) : (crc_q >> 1);
        push_byte(value, 1'b0);
    endfunction

    function automatic void push_word(logic [31:0] v, bit with_crc);
        for (int s = 3; s >= 0; s--)
            if (with_crc)
                push_crc_byte(v[s*8 +: 8]);
            else
                push_byte(v[s*8 +: 8], 1'b0);
    endfunction

    function automatic void push_chunk_type(logic [31:0] name);
        crc_q = CRC_INIT;
        push_word(name, 1'b1);
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_dim(logic [SIZE_W-1:0] v, int unsigned lim);
        if (v == 0)
            return SIZE_W'(1);
        return (v > lim) ? SIZE_W'(lim) : v;
    endfunction

    // one byte of zlib payload, opening a stored block where one is due
    function automatic void push_raw_byte(logic [7:0] b);
        logic [15:0] n;
        int unsigned tmp;
        if (block_left == 0)
        begin
            n = (raw_left > 65535) ? 16'hffff : raw_left[15:0];
            push_crc_byte((raw_left <= 65535) ? 8'd1 : 8'd0);
            push_crc_byte(n[7:0]);
            push_crc_byte(n[15:8]);
            push_crc_byte(~n[7:0]);
            push_crc_byte(~n[15:8]);
            block_left = n;
        end
        push_crc_byte(b);
        tmp = adler_a + b;
        adler_a = 16'(tmp % ADLER_MOD);
        tmp = adler_b + adler_a;
        adler_b = 16'(tmp % ADLER_MOD);
        if (block_left > 0)
            block_left--;
        if (raw_left > 0)
            raw_left--;
    endfunction

    function automatic void push_trailer();
        push_crc_byte(adler_b[15:8]);
        push_crc_byte(adler_b[7:0]);
        push_crc_byte(adler_a[15:8]);
        push_crc_byte(adler_a[7:0]);
        push_word(crc_q ^ CRC_INIT, 1'b0);
        push_word(32'd0, 1'b0);
        push_chunk_type(CHUNK_IEND);
        crc_q = crc_q ^ CRC_INIT;
        push_byte(crc_q[31:24], 1'b0);
        push_byte(crc_q[23:16], 1'b0);
        push_byte(crc_q[15:8], 1'b0);
        push_byte(crc_q[7:0], 1'b1);
        crc_q        = CRC_INIT;
        header_done  = 1'b0;
        trailer_owed = 1'b0;
    endfunction

    function automatic void push_header(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        logic [31:0] raw;
        logic [31:0] blocks;
        raw    = 32'(h) * (32'd1 + 32'd3 * 32'(w));
        blocks = (raw + 32'd65534) / 32'd65535;
        for (int i = 7; i >= 0; i--)
            push_byte(PNG_SIG[i*8 +: 8], 1'b0);
        push_word(IHDR_LEN, 1'b0);
        push_chunk_type(CHUNK_IHDR);
        push_word(32'(w), 1'b1);
        push_word(32'(h), 1'b1);
        push_crc_byte(BIT_DEPTH);
        push_crc_byte(COLOUR_RGB);
        push_crc_byte(8'd0);
        push_crc_byte(8'd0);
        push_crc_byte(8'd0);
        push_word(crc_q ^ CRC_INIT, 1'b0);
        push_word(32'd2 + 32'd5 * blocks + raw + 32'd4, 1'b0);
        push_chunk_type(CHUNK_IDAT);
        push_crc_byte(ZLIB_CMF);
        push_crc_byte(ZLIB_FLG);
        adler_a     = 16'd1;
        adler_b     = 16'd0;
        col_pos     = '0;
        row_pos     = '0;
        block_left  = '0;
        raw_left    = raw[RAW_W-1:0];
        header_done = 1'b1;
    endfunction

    // file bytes caused by one accepted pixel
    function automatic void encode_pixel(pixel_req_t p);
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        w = clamp_dim(reg_width, MAX_WIDTH);
        h = clamp_dim(reg_height, MAX_HEIGHT);
        step_bytes = 0;
        if (trailer_owed)
        begin
            push_trailer();
            return;
        end
        if (!header_done)
            push_header(w, h);
        if (col_pos == 0)
            push_raw_byte(8'h00);
        push_raw_byte(p.red);
        push_raw_byte(p.green);
        push_raw_byte(p.blue);
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = '0;
            row_pos++;
            if (row_pos >= h)
            begin
                if (step_bytes + TRAILER_LEN <= STEP_BYTES_MAX)
                    push_trailer();
                else
                    trailer_owed = 1'b1;
            end
        end
    endfunction

    function automatic void queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit hold);
        pixel_req_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.hold  = hold;
        pixels_pending.push_back(p);
        pixels_outstanding++;
    endfunction

    task automatic wait_idle();
        while (pixels_outstanding != 0 || bytes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_WIDTH)
            reg_width = value;
        else
            reg_height = value;
        header_done  = 1'b0;
        trailer_owed = 1'b0;
        crc_q        = CRC_INIT;
        block_left   = '0;
        raw_left     = '0;
        col_pos      = '0;
        row_pos      = '0;
        reg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(bit set_w, logic [CFG_DATA_W-1:0] wv, bit set_h,
                             logic [CFG_DATA_W-1:0] hv, int unsigned gmax, int unsigned smax);
        wait_idle();
        if (set_w)
            write_reg(CFG_WIDTH, wv);
        if (set_h)
            write_reg(CFG_HEIGHT, hv);
        // wait while the new sizes pass through the size pipeline to the header logic
        repeat (6) @(posedge clk);
        gap_max   = gmax;
        stall_max = smax;
    endtask

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        logic v_next;
        if (!rst_n)
        begin
            pix_ch.valid       <= 1'b0;
            pix_ch.pixel_red   <= '0;
            pix_ch.pixel_green <= '0;
            pix_ch.pixel_blue  <= '0;
            gap_left = 0;
        end
        else
        begin
            v_next = pix_ch.valid;
            if (pix_ch.valid && pix_ch.ready)
            begin
                encode_pixel(pix_cur);
                pixels_outstanding--;
                pixels_sent++;
                v_next   = 1'b0;
                gap_left = $urandom_range(0, gap_max);
            end
            if (!v_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pixels_pending.size() > 0 &&
                         (!pixels_pending[0].hold || bytes_due.size() == 0))
                begin
                    pix_cur = pixels_pending.pop_front();
                    pix_ch.pixel_red   <= pix_cur.red;
                    pix_ch.pixel_green <= pix_cur.green;
                    pix_ch.pixel_blue  <= pix_cur.blue;
                    v_next = 1'b1;
                end
            end
            pix_ch.valid <= v_next;
        end
    end

    // stream monitor
    always @(posedge clk or negedge rst_n)
    begin
        file_byte_t want;
        if (!rst_n)
        begin
            byte_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                bytes_seen++;
                if (byte_ch.last_byte)
                    files_closed++;
                if (bytes_due.size() == 0)
                    flag_failure($sformatf("stream byte %0d: got %02h last %0b, none expected",
                                           bytes_seen, byte_ch.out_byte, byte_ch.last_byte));
                else
                begin
                    want = bytes_due.pop_front();
                    if (byte_ch.out_byte !== want.value || byte_ch.last_byte !== want.last)
                        flag_failure($sformatf(
                            "stream byte %0d: expected %02h last %0b, got %02h last %0b",
                            bytes_seen, want.value, want.last,
                            byte_ch.out_byte, byte_ch.last_byte));
                end
                stall_left = $urandom_range(0, stall_max);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                byte_ch.ready <= 1'b0;
            end
            else
                byte_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("png_stored_rgb_encoder: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned n;
        int unsigned steps;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned pick;
        int unsigned hold_at;
        int unsigned random_count;
        logic [CFG_DATA_W-1:0] wv;
        logic [CFG_DATA_W-1:0] hv;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_WIDTH;
        cfg_data            = '0;
        reg_width           = 1;
        reg_height          = 1;
        crc_q               = CRC_INIT;
        adler_a             = 16'd1;
        adler_b             = 16'd0;
        col_pos             = '0;
        row_pos             = '0;
        block_left          = '0;
        raw_left            = '0;
        header_done         = 1'b0;
        trailer_owed        = 1'b0;
        pixels_outstanding  = 0;
        pixels_sent         = 0;
        bytes_seen          = 0;
        files_closed        = 0;
        reg_writes          = 0;
        failures            = 0;
        gap_max             = 11;
        stall_max           = 11;
        random_count        = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: one pixel images, trailer on the following request
        queue_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        queue_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        queue_pixel(8'ha5, 8'h5a, 8'ha5, 1'b0);
        queue_pixel(8'h5a, 8'ha5, 8'h5a, 1'b0);

        // zero sizes read as one
        configure(1'b1, '0, 1'b1, '0, 11, 0);
        queue_pixel(8'h01, 8'h02, 8'h04, 1'b0);
        queue_pixel(8'h80, 8'h40, 8'h20, 1'b0);

        // small image, then one pixel of the next image left open
        configure(1'b1, 14'd3, 1'b1, 14'd2, 11, 11);
        queue_pixel(8'hff, 8'h00, 8'hff, 1'b0);
        queue_pixel(8'h00, 8'hff, 8'h00, 1'b0);
        queue_pixel(8'h55, 8'haa, 8'h55, 1'b0);
        queue_pixel(8'haa, 8'h55, 8'haa, 1'b1);
        queue_pixel(8'h0f, 8'hf0, 8'h0f, 1'b0);
        queue_pixel(8'hf0, 8'h0f, 8'hf0, 1'b0);
        queue_pixel(8'h12, 8'h34, 8'h56, 1'b0);

        // sizes above the maximum, image abandoned by the next write
        configure(1'b1, 14'd16383, 1'b1, 14'd8193, 0, 11);
        for (int i = 0; i < 3; i++)
            queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        // full-width rows, first stored block not the final one, image left open
        configure(1'b1, 14'd8192, 1'b1, 14'd3, 0, 0);
        for (int i = 0; i < 8; i++)
            queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

        while (random_count < RANDOM_PIXELS)
        begin
            pick = $urandom_range(0, 9);
            wv = (pick == 0) ? '0 : (pick == 1) ? CFG_DATA_W'($urandom_range(9, 40))
                                               : CFG_DATA_W'($urandom_range(1, 6));
            pick = $urandom_range(0, 9);
            hv = (pick == 0) ? '0 : (pick == 1) ? CFG_DATA_W'($urandom_range(5, 20))
                                               : CFG_DATA_W'($urandom_range(1, 4));
            pick = $urandom_range(0, 3);
            configure(pick != 1, wv, pick != 0, hv,
                      $urandom_range(0, 1) ? 11 : 0, $urandom_range(0, 1) ? 11 : 0);
            w_eff = clamp_dim(reg_width, MAX_WIDTH);
            h_eff = clamp_dim(reg_height, MAX_HEIGHT);
            steps = w_eff * h_eff + ((w_eff * h_eff == 1) ? 1 : 0);
            n = steps * $urandom_range(1, 2);
            // broken images now and then, cut short by the next write
            if ($urandom_range(0, 4) == 0 || n > 48)
                n = $urandom_range(1, (n > 48) ? 48 : n);
            if (n > RANDOM_PIXELS - random_count)
                n = RANDOM_PIXELS - random_count;
            hold_at = $urandom_range(0, 3 * n);
            for (int i = 0; i < n; i++)
                queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), i == hold_at);
            random_count += n;
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (bytes_due.size() != 0)
            flag_failure($sformatf("%0d stream bytes never arrived", bytes_due.size()));

        $display("png_stored_rgb_encoder_tb: %0d pixels in, %0d file bytes checked, %0d files closed",
                 pixels_sent, bytes_seen, files_closed);
        $display("png_stored_rgb_encoder_tb: %0d size writes, 1x1 up to 8192x3 and clamped sizes",
                 reg_writes);
        if (failures == 0)
            $display("png_stored_rgb_encoder: match");
        else
            $display("png_stored_rgb_encoder: mismatch");
        $finish;
    end

endmodule
